### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rfas_pkg.sv
package rfas_pkg;

    // Pipeline geometry.
    localparam int SQ_N    = 49;            // root bits, one per stage
    localparam int DIV_N   = 64;            // quotient bits of the field strength
    localparam int UDIV_N  = 31;            // quotient bits of each unit vector part
    localparam int ST_S4   = 4;             // surface compare stage
    localparam int ST_SQ0  = ST_S4 + 1;
    localparam int ST_R1   = ST_SQ0 + SQ_N;
    localparam int ST_R2   = ST_R1 + 1;
    localparam int ST_DIV0 = ST_R2 + 1;
    localparam int ST_P1   = ST_DIV0 + DIV_N;
    localparam int ST_P2   = ST_P1 + 1;
    localparam int ST_C1   = ST_P2 + 1;
    localparam int ST_C2   = ST_C1 + 1;
    localparam int ST_A1   = ST_C2 + 1;
    localparam int ST_A2   = ST_A1 + 1;
    localparam int NST     = ST_A2 + 1;

    localparam logic [63:0] SMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN       = 64'h8000_0000_0000_0000;
    localparam logic [59:0] MU_RESET   = 60'd398600441800000;
    localparam logic [31:0] RAD_RESET  = 32'd6371000;
    localparam logic [39:0] FUEL_STEP  = 40'd128;
    localparam int          CFG_IDX_W  = 3;
    localparam int          CFG_DATA_W = 60;

    typedef logic [97:0] t_sq;
    typedef logic [98:0] t_rem;
    typedef logic [48:0] t_root;
    typedef logic [63:0] t_quo;
    typedef logic [49:0] t_udiv;
    typedef logic [30:0] t_uquo;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANET_X      = 3'd0,
        CFG_PLANET_Y      = 3'd1,
        CFG_PLANET_Z      = 3'd2,
        CFG_PLANET_MU     = 3'd3,
        CFG_PLANET_RADIUS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [39:0] fuel_in;
        logic        [39:0] dry_mass;
        logic signed [63:0] force_in_x;
        logic signed [63:0] force_in_y;
        logic signed [63:0] force_in_z;
    } t_in;

    typedef struct packed {
        logic signed [63:0] force_out_x;
        logic signed [63:0] force_out_y;
        logic signed [63:0] force_out_z;
        logic signed [39:0] fuel_out;
        logic               inside_planet;
    } t_out;

    // Fields that ride along with a request through the whole pipeline.
    typedef struct packed {
        logic [2:0][63:0] force_acc;
        logic [2:0][15:0] dir;
        logic [39:0]      fuel;
        logic             fuel_pos;
        logic [2:0]       neg;
        logic [2:0][48:0] a;
        logic [40:0]      mabs;
        logic             gvalid;
        logic             in_planet;
    } t_pass;

endpackage

### sv/rfas_sat_add.sv
module rfas_sat_add (
    input  logic [63:0] i_acc,
    input  logic        i_neg,
    input  logic [63:0] i_mag,
    output logic [63:0] o_sum
);

    logic [65:0] w_ext;
    logic [65:0] w_mag;
    logic [65:0] w_sum;
    logic        w_hi;
    logic        w_lo;

    assign w_ext = {{2{i_acc[63]}}, i_acc};
    assign w_mag = {2'b00, i_mag};
    assign w_sum = i_neg ? (w_ext - w_mag) : (w_ext + w_mag);
    // The three top bits agree only when the result fits in 64 signed bits.
    assign w_hi  = !w_sum[65] && (w_sum[64] || w_sum[63]);
    assign w_lo  = w_sum[65] && !(w_sum[64] && w_sum[63]);

    always_comb begin
        if (w_hi) begin
            o_sum = rfas_pkg::SMAX;
        end else if (w_lo) begin
            o_sum = rfas_pkg::SMIN;
        end else begin
            o_sum = w_sum[63:0];
        end
    end

endmodule

### sv/rocket_force_accumulate_step_core.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_in  (rfas_pkg::t_in)
// out     | output    | o_out_valid / i_out_stall  | o_out (rfas_pkg::t_out)
// cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One request enters per clock while no result waits at the output under stall.
// The pipeline is dominated by the 49-stage square root and the 64-stage quotient of the
// field strength; the unit-vector quotients run alongside the latter.
// Reset clears the stage valid bits and loads the planet registers with defaults.
// When a result waits at the output under stall, the whole pipeline holds.
module rocket_force_accumulate_step_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rfas_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rfas_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  logic [rfas_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rfas_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [47:0] r_planet_x;
    logic [47:0] r_planet_y;
    logic [47:0] r_planet_z;
    logic [59:0] r_planet_mu;
    logic [31:0] r_planet_radius;

    logic                      w_en;
    logic [rfas_pkg::NST-1:0]  r_valid;
    rfas_pkg::t_pass           r_pass [rfas_pkg::NST];
    rfas_pkg::t_pass           n_pass [rfas_pkg::NST];

    logic [2:0][49:0] r_pll;
    logic [2:0][48:0] r_plh;
    logic [2:0][47:0] r_phh;
    logic [63:0]      r_rad2_1;
    logic [63:0]      r_rad2_2;
    logic [63:0]      r_rad2_3;
    rfas_pkg::t_sq    r_sq [3];
    rfas_pkg::t_sq    r_ssum;
    rfas_pkg::t_sq    r_s4;

    rfas_pkg::t_rem   r_rem  [rfas_pkg::SQ_N];
    rfas_pkg::t_root  r_root [rfas_pkg::SQ_N];

    logic [49:0]      r_rll;
    logic [48:0]      r_rlh;
    logic [47:0]      r_rhh;
    rfas_pkg::t_root  r_rr1;
    rfas_pkg::t_sq    r_r2;
    rfas_pkg::t_root  r_rr2;

    rfas_pkg::t_rem   r_gr   [rfas_pkg::DIV_N];
    rfas_pkg::t_quo   r_gq   [rfas_pkg::DIV_N];
    rfas_pkg::t_sq    r_gd   [rfas_pkg::DIV_N];
    logic             r_gsat [rfas_pkg::DIV_N];
    rfas_pkg::t_root  r_rr   [rfas_pkg::UDIV_N];
    logic [2:0][49:0] r_ur   [rfas_pkg::UDIV_N];
    logic [2:0][30:0] r_uq   [rfas_pkg::DIV_N];

    logic [63:0]      r_pm0;
    logic [63:0]      r_pm1;
    logic [40:0]      r_pm2;
    logic [40:0]      r_pm3;
    logic [2:0][30:0] r_u1;
    logic [80:0]      r_p;
    logic [2:0][30:0] r_u2;
    logic [2:0][2:0][57:0] r_cp;
    logic [2:0][63:0] r_cm;
    logic signed [27:0] r_th [3];

    logic [2:0][63:0] w_gsum;
    logic [2:0][63:0] w_tsum;
    logic [2:0][63:0] w_tmag;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planet_x      <= '0;
            r_planet_y      <= '0;
            r_planet_z      <= '0;
            r_planet_mu     <= rfas_pkg::MU_RESET;
            r_planet_radius <= rfas_pkg::RAD_RESET;
        end else if (i_cfg_we) begin
            case (rfas_pkg::t_cfg_idx'(i_cfg_idx))
                rfas_pkg::CFG_PLANET_X:      r_planet_x      <= i_cfg_data[47:0];
                rfas_pkg::CFG_PLANET_Y:      r_planet_y      <= i_cfg_data[47:0];
                rfas_pkg::CFG_PLANET_Z:      r_planet_z      <= i_cfg_data[47:0];
                rfas_pkg::CFG_PLANET_MU:     r_planet_mu     <= i_cfg_data[59:0];
                rfas_pkg::CFG_PLANET_RADIUS: r_planet_radius <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    assign w_en        = !(r_valid[rfas_pkg::NST-1] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_valid[rfas_pkg::NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[rfas_pkg::NST-2:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------- side fields
    always_comb begin
        logic [2:0][47:0] pos;
        logic [2:0][47:0] ctr;
        logic [2:0][48:0] d;
        logic [41:0]      m;
        logic             m_pos;
        pos = {i_in.pos_z, i_in.pos_y, i_in.pos_x};
        ctr = {r_planet_z, r_planet_y, r_planet_x};
        m   = {2'b00, i_in.dry_mass} + {{2{i_in.fuel_in[39]}}, i_in.fuel_in};
        m_pos = !m[41] && (m != '0);
        n_pass[0].force_acc = {i_in.force_in_z, i_in.force_in_y, i_in.force_in_x};
        n_pass[0].dir       = {i_in.dir_z, i_in.dir_y, i_in.dir_x};
        n_pass[0].fuel      = i_in.fuel_in;
        n_pass[0].fuel_pos  = !i_in.fuel_in[39] && (i_in.fuel_in != '0);
        n_pass[0].mabs      = m[41] ? 41'(~m + 42'd1) : m[40:0];
        n_pass[0].gvalid    = 1'b0;
        n_pass[0].in_planet = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d[i] = {pos[i][47], pos[i]} - {ctr[i][47], ctr[i]};
            n_pass[0].a[i]   = d[i][48] ? (~d[i] + 49'd1) : d[i];
            // Gravity pulls against the displacement; a negative mass flips it.
            n_pass[0].neg[i] = (m_pos && !d[i][48] && (d[i] != '0)) || (m[41] && d[i][48]);
        end
        for (int k = 1; k < rfas_pkg::NST; k++) begin
            n_pass[k] = r_pass[k-1];
        end
        n_pass[rfas_pkg::ST_S4].in_planet =
            (r_ssum < {2'b00, r_rad2_3, 32'd0});
        n_pass[rfas_pkg::ST_S4].gvalid =
            !(r_ssum < {2'b00, r_rad2_3, 32'd0}) && (r_ssum != '0);
        for (int i = 0; i < 3; i++) begin
            n_pass[rfas_pkg::ST_A1].force_acc[i] =
                r_pass[rfas_pkg::ST_A1-1].gvalid ? w_gsum[i]
                                                 : r_pass[rfas_pkg::ST_A1-1].force_acc[i];
            n_pass[rfas_pkg::ST_A2].force_acc[i] =
                r_pass[rfas_pkg::ST_A2-1].fuel_pos ? w_tsum[i]
                                                   : r_pass[rfas_pkg::ST_A2-1].force_acc[i];
        end
        n_pass[rfas_pkg::ST_A2].fuel = r_pass[rfas_pkg::ST_A2-1].fuel_pos ?
            (r_pass[rfas_pkg::ST_A2-1].fuel - rfas_pkg::FUEL_STEP) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < rfas_pkg::NST; k++) begin
                r_pass[k] <= n_pass[k];
            end
        end
    end

    // ---------------------------------------------------------------- distance squared
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pll[i] <= {25'd0, r_pass[0].a[i][24:0]} * {25'd0, r_pass[0].a[i][24:0]};
                r_plh[i] <= {24'd0, r_pass[0].a[i][24:0]} * {25'd0, r_pass[0].a[i][48:25]};
                r_phh[i] <= {24'd0, r_pass[0].a[i][48:25]} * {24'd0, r_pass[0].a[i][48:25]};
                r_sq[i]  <= (rfas_pkg::t_sq'(r_phh[i]) << 50)
                          + (rfas_pkg::t_sq'(r_plh[i]) << 26)
                          + rfas_pkg::t_sq'(r_pll[i]);
            end
            r_rad2_1 <= {32'd0, r_planet_radius} * {32'd0, r_planet_radius};
            r_rad2_2 <= r_rad2_1;
            r_rad2_3 <= r_rad2_2;
            r_ssum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_s4     <= r_ssum;
        end
    end

    // ---------------------------------------------------------------- square root
    // Digit recurrence: the remainder holds S minus the square of the partial root.
    for (genvar k = 0; k < rfas_pkg::SQ_N; k++) begin : g_sqrt
        localparam int B = rfas_pkg::SQ_N - 1 - k;
        rfas_pkg::t_rem  w_rem_in;
        rfas_pkg::t_rem  w_trial;
        rfas_pkg::t_root w_root_in;
        logic            w_ge;
        if (k == 0) begin : g_head
            assign w_rem_in  = {1'b0, r_s4};
            assign w_root_in = '0;
        end else begin : g_body
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end
        assign w_trial = (rfas_pkg::t_rem'(w_root_in) << (B + 1))
                       | (rfas_pkg::t_rem'(1) << (2 * B));
        assign w_ge    = (w_rem_in >= w_trial);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[k]  <= w_ge ? (w_rem_in - w_trial) : w_rem_in;
                r_root[k] <= w_ge ? (w_root_in | (rfas_pkg::t_root'(1) << B)) : w_root_in;
            end
        end
    end

    // ---------------------------------------------------------------- r squared
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rll <= {25'd0, r_root[rfas_pkg::SQ_N-1][24:0]}
                   * {25'd0, r_root[rfas_pkg::SQ_N-1][24:0]};
            r_rlh <= {24'd0, r_root[rfas_pkg::SQ_N-1][24:0]}
                   * {25'd0, r_root[rfas_pkg::SQ_N-1][48:25]};
            r_rhh <= {24'd0, r_root[rfas_pkg::SQ_N-1][48:25]}
                   * {24'd0, r_root[rfas_pkg::SQ_N-1][48:25]};
            r_rr1 <= r_root[rfas_pkg::SQ_N-1];
            r_r2  <= (rfas_pkg::t_sq'(r_rhh) << 50) + (rfas_pkg::t_sq'(r_rlh) << 26)
                   + rfas_pkg::t_sq'(r_rll);
            r_rr2 <= r_rr1;
        end
    end

    // ---------------------------------------------------------------- quotients
    // Field strength mu * 2^64 / r^2 saturates exactly when mu >= r^2, so the
    // recurrence starts from mu and only produces the low 64 quotient bits.
    for (genvar j = 0; j < rfas_pkg::DIV_N; j++) begin : g_div
        rfas_pkg::t_rem  w_gr_in;
        rfas_pkg::t_rem  w_gsh;
        rfas_pkg::t_quo  w_gq_in;
        rfas_pkg::t_sq   w_gd_in;
        logic            w_gsat_in;
        logic            w_gge;
        logic [2:0][30:0] w_uq_in;
        if (j == 0) begin : g_head
            assign w_gr_in   = rfas_pkg::t_rem'(r_planet_mu);
            assign w_gq_in   = '0;
            assign w_gd_in   = r_r2;
            assign w_gsat_in = (rfas_pkg::t_sq'(r_planet_mu) >= r_r2);
            assign w_uq_in   = '0;
        end else begin : g_body
            assign w_gr_in   = r_gr[j-1];
            assign w_gq_in   = r_gq[j-1];
            assign w_gd_in   = r_gd[j-1];
            assign w_gsat_in = r_gsat[j-1];
            assign w_uq_in   = r_uq[j-1];
        end
        assign w_gsh = {w_gr_in[97:0], 1'b0};
        assign w_gge = (w_gsh >= {1'b0, w_gd_in});
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_gr[j]   <= w_gge ? (w_gsh - {1'b0, w_gd_in}) : w_gsh;
                r_gq[j]   <= {w_gq_in[62:0], w_gge};
                r_gd[j]   <= w_gd_in;
                r_gsat[j] <= w_gsat_in;
            end
        end

        if (j < rfas_pkg::UDIV_N) begin : g_unit
            // Each axis forms a_i * 2^30 / r; a_i never exceeds r.
            rfas_pkg::t_root  w_rr_in;
            logic [2:0][49:0] w_ur_in;
            logic [2:0][49:0] w_ush;
            logic [2:0]       w_uge;
            if (j == 0) begin : g_uhead
                assign w_rr_in = r_rr2;
                for (genvar i = 0; i < 3; i++) begin : g_ax
                    assign w_ur_in[i] = {2'b00, r_pass[rfas_pkg::ST_DIV0-1].a[i][48:1]};
                    assign w_ush[i]   = {w_ur_in[i][48:0], r_pass[rfas_pkg::ST_DIV0-1].a[i][0]};
                end
            end else begin : g_ubody
                assign w_rr_in = r_rr[j-1];
                for (genvar i = 0; i < 3; i++) begin : g_ax
                    assign w_ur_in[i] = r_ur[j-1][i];
                    assign w_ush[i]   = {w_ur_in[i][48:0], 1'b0};
                end
            end
            for (genvar i = 0; i < 3; i++) begin : g_cmp
                assign w_uge[i] = (w_ush[i] >= {1'b0, w_rr_in});
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rr[j] <= w_rr_in;
                    for (int i = 0; i < 3; i++) begin
                        r_ur[j][i] <= w_uge[i] ? (w_ush[i] - {1'b0, w_rr_in}) : w_ush[i];
                        r_uq[j][i] <= {w_uq_in[i][29:0], w_uge[i]};
                    end
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_uq[j] <= w_uq_in;
                end
            end
        end
    end

    // ---------------------------------------------------------------- force magnitudes
    always_ff @(posedge i_clk) begin
        logic [63:0] g;
        logic [40:0] m;
        g = r_gsat[rfas_pkg::DIV_N-1] ? '1 : r_gq[rfas_pkg::DIV_N-1];
        m = r_pass[rfas_pkg::ST_P1-1].mabs;
        if (w_en) begin
            r_pm0 <= {32'd0, m[31:0]} * {32'd0, g[31:0]};
            r_pm1 <= {32'd0, m[31:0]} * {32'd0, g[63:32]};
            r_pm2 <= {32'd0, m[40:32]} * {9'd0, g[31:0]};
            r_pm3 <= {32'd0, m[40:32]} * {9'd0, g[63:32]};
            r_u1  <= r_uq[rfas_pkg::DIV_N-1];
            r_p   <= 81'(((106'(r_pm0) + (106'(r_pm1) << 32) + (106'(r_pm2) << 32)
                         + (106'(r_pm3) << 64)) >> 24));
            r_u2  <= r_u1;
            for (int i = 0; i < 3; i++) begin
                r_cp[i][0] <= {31'd0, r_p[26:0]}  * {27'd0, r_u2[i]};
                r_cp[i][1] <= {31'd0, r_p[53:27]} * {27'd0, r_u2[i]};
                r_cp[i][2] <= {31'd0, r_p[80:54]} * {27'd0, r_u2[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [111:0] t;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                t = 112'(r_cp[i][0]) + (112'(r_cp[i][1]) << 27) + (112'(r_cp[i][2]) << 54);
                r_cm[i] <= (t[111:94] != '0) ? '1 : t[93:30];
                r_th[i] <= 28'($signed(r_pass[rfas_pkg::ST_A1-1].dir[i])) * 28'sd1550;
            end
        end
    end

    // ---------------------------------------------------------------- accumulation
    for (genvar i = 0; i < 3; i++) begin : g_acc
        assign w_tmag[i] = r_th[i][27] ? 64'(-r_th[i]) : 64'(r_th[i]);

        rfas_sat_add u_grav (
            .i_acc (r_pass[rfas_pkg::ST_A1-1].force_acc[i]),
            .i_neg (r_pass[rfas_pkg::ST_A1-1].neg[i]),
            .i_mag (r_cm[i]),
            .o_sum (w_gsum[i])
        );

        rfas_sat_add u_thrust (
            .i_acc (r_pass[rfas_pkg::ST_A2-1].force_acc[i]),
            .i_neg (r_th[i][27]),
            .i_mag (w_tmag[i]),
            .o_sum (w_tsum[i])
        );
    end

    assign o_out.force_out_x   = r_pass[rfas_pkg::NST-1].force_acc[0];
    assign o_out.force_out_y   = r_pass[rfas_pkg::NST-1].force_acc[1];
    assign o_out.force_out_z   = r_pass[rfas_pkg::NST-1].force_acc[2];
    assign o_out.fuel_out      = r_pass[rfas_pkg::NST-1].fuel;
    assign o_out.inside_planet = r_pass[rfas_pkg::NST-1].in_planet;

endmodule

### sv/rfas_checker.sv
`include "assert_macros.svh"

module rfas_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input rfas_pkg::t_in                   i_in,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input rfas_pkg::t_out                  o_out,
    input logic                            i_cfg_we,
    input logic [rfas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [rfas_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // The input side only backs up when a result is held at the output.
    `ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without output back-pressure")

    // A held result stays on the port unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")

    // Reset flushes the pipeline: no result right after it.
    `ASSERT_SAME(a_reset_flush, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid, "result shown right after reset")

    // Burning fuel removes one FUEL_STEP of 128 at most, so the fuel never drops below -127.
    `ASSERT_SAME(a_fuel_floor, i_clk, i_rst_n, o_out_valid, $signed(o_out.fuel_out) >= -40'sd127, "fuel result below one burn step")

endmodule

bind rocket_force_accumulate_step_core rfas_checker u_rfas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data)
);
